// ----- design/assert_macros.svh -----
// Assertion macros used by fft_bin_magnitude_to_db.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk_i, switched off while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- design/fbmdb_pkg.sv -----
package fbmdb_pkg;

  // Default sizes.
  localparam int unsigned SAMPLE_BITS_DEF       = 16;
  localparam int unsigned LOG_FRACTION_BITS_DEF = 5;

  // Fixed field widths.
  localparam int unsigned LEVEL_W = 15;
  localparam int unsigned GAIN_W  = 12;
  localparam int unsigned CFG_W   = GAIN_W;

  // Level limits and the zero-power sentinel, in 1/16 dB.
  localparam int LEVEL_MIN  = -16384;
  localparam int LEVEL_MAX  = 16383;
  localparam int ZERO_LEVEL = -10656;

  // 16 * 10 * log10(2) in Q.16.
  localparam int DB_SCALE_Q16 = 3156528;

  // 2 * log2(full scale) for the two full-scale settings.
  localparam int FS_BITS_LO = 14;
  localparam int FS_BITS_HI = 22;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    RegFullScale = 1'b0,
    RegGain      = 1'b1
  } cfg_reg_e;

  // Q.16 log2 of (1 + m / 2^fbits), by repeated squaring of a Q.30 mantissa.
  // Only evaluated on constants to build the fraction table.
  function automatic logic [15:0] frac_log2(input int unsigned m, input int unsigned fbits);
    logic [63:0] x;
    logic [15:0] r;
    x = (64'd1 << fbits) + 64'(m);
    x = x << (30 - fbits);
    r = '0;
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      r = {r[14:0], 1'b0};
      if (x >= (64'd2 << 30)) begin
        r[0] = 1'b1;
        x    = x >> 1;
      end
    end
    return r;
  endfunction

endpackage

// ----- design/fft_bin_magnitude_to_db.sv -----
// Channel   Direction  Handshake                 Payload
// command   in         start / busy              real_part_i, imag_part_i, last_bin_i
// result    out        result_valid_o (strobe)   level_db_o, zero_power_o, last_bin_out_o
// config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One bin is taken every clock; busy is never raised.
// Each result leaves once its bin has passed through every stage, in order of arrival.
// The seven stages are: squares, power sum, leading-one search, normalize shift,
// fraction table and offset, dB scale multiply, round/gain/saturate.
// Reset clears the valid bits of all stages and both configuration registers.
// The receiver cannot hold results off, so the pipeline never stalls.
module fft_bin_magnitude_to_db #(
  parameter int unsigned SAMPLE_BITS       = fbmdb_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned LOG_FRACTION_BITS = fbmdb_pkg::LOG_FRACTION_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [SAMPLE_BITS-1:0]         real_part_i,
  input  logic signed [SAMPLE_BITS-1:0]         imag_part_i,
  input  logic                                  last_bin_i,
  output logic                                  result_valid_o,
  output logic signed [fbmdb_pkg::LEVEL_W-1:0]  level_db_o,
  output logic                                  zero_power_o,
  output logic                                  last_bin_out_o,
  input  logic                                  cfg_we_i,
  input  logic [0:0]                            cfg_idx_i,
  input  logic [fbmdb_pkg::CFG_W-1:0]           cfg_data_i
);
  import fbmdb_pkg::*;

`include "assert_macros.svh"

  localparam int unsigned SqW         = 2 * SAMPLE_BITS - 1;
  localparam int unsigned PW          = 2 * SAMPLE_BITS;
  localparam int unsigned EW          = $clog2(PW);
  localparam int unsigned FW          = LOG_FRACTION_BITS;
  localparam int unsigned FracEntries = 1 << FW;
  localparam int unsigned XW          = EW + 18;
  localparam int unsigned ProdW       = XW + 23;
  localparam int unsigned RawW        = ProdW - 32;
  localparam int unsigned SumW        = ((RawW > GAIN_W) ? RawW : GAIN_W) + 2;
  localparam int unsigned Latency     = 7;

  localparam logic signed [XW-1:0]    FsOffLo   = XW'(FS_BITS_LO * 65536);
  localparam logic signed [XW-1:0]    FsOffHi   = XW'(FS_BITS_HI * 65536);
  localparam logic signed [22:0]      DbScale   = 23'(DB_SCALE_Q16);
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(64'd1 << 31);
  localparam logic signed [SumW-1:0]  SatLo     = SumW'(LEVEL_MIN);
  localparam logic signed [SumW-1:0]  SatHi     = SumW'(LEVEL_MAX);
  localparam logic [EW-1:0]           TopIdx    = EW'(PW - 1);

  // Configuration registers.
  logic              fs_sel_q;
  logic [GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_sel_q <= 1'b0;
      gain_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegFullScale: fs_sel_q <= cfg_data_i[0];
        RegGain:      gain_q   <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Fraction table, built at elaboration.
  logic [15:0] frac_rom [FracEntries];
  for (genvar g = 0; g < FracEntries; g++) begin : g_rom
    assign frac_rom[g] = frac_log2(g, FW);
  end

  // Valid bits travel with the data through all stages.
  logic [Latency-1:0] vld_q;
  logic [Latency-1:0] last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], start};
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= {last_q[Latency-2:0], last_bin_i};
  end

  // Stage 1: squares of both parts.
  logic signed [PW-1:0] sq_re_full, sq_im_full;
  logic [SqW-1:0]       sq_re_q, sq_im_q;

  assign sq_re_full = real_part_i * real_part_i;
  assign sq_im_full = imag_part_i * imag_part_i;

  always_ff @(posedge clk_i) begin
    sq_re_q <= sq_re_full[SqW-1:0];
    sq_im_q <= sq_im_full[SqW-1:0];
  end

  // Stage 2: power sum and zero detect.
  logic [PW-1:0] pow_d, pow_q;
  logic          zero_q [6];

  assign pow_d = {1'b0, sq_re_q} + {1'b0, sq_im_q};

  always_ff @(posedge clk_i) begin
    pow_q     <= pow_d;
    zero_q[0] <= (pow_d == '0);
  end

  // Stage 3: position of the leading one.
  logic [EW-1:0] lead_d, lead_q;
  logic [PW-1:0] pow3_q;

  always_comb begin
    lead_d = '0;
    for (int i = 0; i < PW; i++) begin
      if (pow_q[i]) begin
        lead_d = EW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lead_q    <= lead_d;
    pow3_q    <= pow_q;
    zero_q[1] <= zero_q[0];
  end

  // Stage 4: normalize so the leading one sits at the top, take the bits below it.
  logic [EW-1:0] shamt;
  logic [PW-1:0] norm;
  logic [FW-1:0] mant_q;
  logic [EW-1:0] lead4_q;

  assign shamt = TopIdx - lead_q;
  assign norm  = pow3_q << shamt;

  always_ff @(posedge clk_i) begin
    mant_q    <= norm[PW-2 -: FW];
    lead4_q   <= lead_q;
    zero_q[2] <= zero_q[1];
  end

  // Stage 5: log2 in Q.16 less the full-scale term.
  logic signed [XW-1:0] x_d, x_q;

  assign x_d = $signed({2'b00, lead4_q, frac_rom[mant_q]}) - (fs_sel_q ? FsOffHi : FsOffLo);

  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    zero_q[3] <= zero_q[2];
  end

  // Stage 6: scale into 1/16 dB.
  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q    <= x_q * DbScale;
    zero_q[4] <= zero_q[3];
  end

  // Stage 7: round half up, subtract the gain, saturate or pick the sentinel.
  logic signed [ProdW-1:0]   rnd;
  logic signed [RawW-1:0]    raw;
  logic signed [SumW-1:0]    lvl_sum;
  logic signed [LEVEL_W-1:0] lvl_d, lvl_q;

  assign rnd     = prod_q + RoundHalf;
  assign raw     = rnd[ProdW-1:32];
  assign lvl_sum = {{(SumW - RawW){raw[RawW-1]}}, raw}
                 - {{(SumW - GAIN_W){gain_q[GAIN_W-1]}}, gain_q};

  always_comb begin
    if (zero_q[4]) begin
      lvl_d = LEVEL_W'(ZERO_LEVEL);
    end else if (lvl_sum < SatLo) begin
      lvl_d = LEVEL_W'(LEVEL_MIN);
    end else if (lvl_sum > SatHi) begin
      lvl_d = LEVEL_W'(LEVEL_MAX);
    end else begin
      lvl_d = lvl_sum[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q     <= lvl_d;
    zero_q[5] <= zero_q[4];
  end

  // Result ports.
  assign result_valid_o = vld_q[Latency-1];
  assign level_db_o     = lvl_q;
  assign zero_power_o   = zero_q[5];
  assign last_bin_out_o = last_q[Latency-1];

  // Every accepted bin produces exactly one result after the pipeline latency.
  `ASSERT_CLK(a_bin_gives_result, start |-> ##7 result_valid_o,
              "accepted bin did not produce a result")
  `ASSERT_CLK(a_result_has_bin, result_valid_o |-> $past(start, 7),
              "result without an accepted bin")
  `ASSERT_CLK(a_zero_sentinel,
              (result_valid_o && zero_power_o) |-> (level_db_o == LEVEL_W'(ZERO_LEVEL)),
              "zero power without the sentinel level")
  `ASSERT_CLK(a_last_follows, result_valid_o |-> (last_bin_out_o == $past(last_bin_i, 7)),
              "last bin marker out of step with its bin")
  `ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |=> !result_valid_o,
                 "result strobe during reset")

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

  import fbmdb_pkg::*;

  localparam int SW        = SAMPLE_BITS_DEF;
  localparam int FRAC_BITS = LOG_FRACTION_BITS_DEF;
  localparam int LIMIT     = 60000;

  typedef logic signed [SW-1:0]      sample_t;
  typedef logic signed [LEVEL_W-1:0] level_t;
  typedef logic signed [GAIN_W-1:0]  gain_t;

  typedef struct {
    level_t level;
    logic   zero;
    logic   last;
  } bin_level_t;

  // Keeps a copy of the two settings, predicts the level of every taken bin
  // and checks each result against the oldest prediction.
  class db_level_board;
    bit            full_scale;
    gain_t         gain;
    bin_level_t    expected_levels[$];
    logic [15:0]   log2_frac_rom[1 << FRAC_BITS];
    int            fail_count;

    function new();
      full_scale = 1'b0;
      gain       = '0;
      fail_count = 0;
      for (int m = 0; m < (1 << FRAC_BITS); m++) begin
        log2_frac_rom[m] = log2_fraction(m);
      end
    endfunction

    // Q.16 log2 of (1 + m / 2^FRAC_BITS): square a Q.30 mantissa sixteen times
    // and take one result bit from each step.
    function logic [15:0] log2_fraction(int unsigned m);
      logic [63:0] mant;
      logic [15:0] bits;
      mant = 64'((1 << FRAC_BITS) + m) << (30 - FRAC_BITS);
      bits = '0;
      for (int i = 0; i < 16; i++) begin
        mant = (mant * mant) >> 30;
        bits = {bits[14:0], 1'b0};
        if (mant >= (64'd2 << 30)) begin
          bits[0] = 1'b1;
          mant    = mant >> 1;
        end
      end
      return bits;
    endfunction

    function void note_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
      case (idx)
        RegFullScale: full_scale = data[0];
        RegGain:      gain = gain_t'(data);
        default:      ;
      endcase
    endfunction

    function bin_level_t predict_level(sample_t re, sample_t im, logic last);
      bin_level_t       res;
      longint           sre;
      longint           sim;
      longint unsigned  pwr;
      int               lead;
      int unsigned      frac_idx;
      longint           x;
      longint           prod;
      longint           lvl;
      int               fs_bits;
      sre      = re;
      sim      = im;
      pwr      = longint'(sre * sre + sim * sim);
      res.last = last;
      // Zero power gives the fixed sentinel; the gain does not touch it.
      if (pwr == 0) begin
        res.level = level_t'(ZERO_LEVEL);
        res.zero  = 1'b1;
        return res;
      end
      lead = 63;
      while (lead > 0 && !pwr[lead]) lead--;
      if (lead >= FRAC_BITS) begin
        frac_idx = int'((pwr >> (lead - FRAC_BITS)) & ((1 << FRAC_BITS) - 1));
      end else begin
        frac_idx = int'((pwr << (FRAC_BITS - lead)) & ((1 << FRAC_BITS) - 1));
      end
      fs_bits = full_scale ? FS_BITS_HI : FS_BITS_LO;
      x = longint'(lead) * 65536 + longint'(log2_frac_rom[frac_idx])
          - longint'(fs_bits) * 65536;
      // Round half up into 1/16 dB, then remove the gain and saturate.
      prod = x * longint'(DB_SCALE_Q16) + (longint'(1) << 31);
      lvl  = (prod >>> 32) - longint'(gain);
      if (lvl < LEVEL_MIN) lvl = LEVEL_MIN;
      if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
      res.level = level_t'(lvl);
      res.zero  = 1'b0;
      return res;
    endfunction

    function void note_bin(sample_t re, sample_t im, logic last);
      expected_levels.push_back(predict_level(re, im, last));
    endfunction

    function void check_level(level_t level, logic zero, logic last);
      bin_level_t want;
      if (expected_levels.size() == 0) begin
        $error("result with no bin waiting: level_db %0d", level);
        fail_count++;
        return;
      end
      want = expected_levels.pop_front();
      if (level !== want.level) begin
        $error("level_db: expected %0d, actual %0d", want.level, level);
        fail_count++;
      end
      if (zero !== want.zero) begin
        $error("zero_power: expected %0b, actual %0b", want.zero, zero);
        fail_count++;
      end
      if (last !== want.last) begin
        $error("last_bin_out: expected %0b, actual %0b", want.last, last);
        fail_count++;
      end
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  sample_t          real_part_i = '0;
  sample_t          imag_part_i = '0;
  logic             last_bin_i  = 1'b0;
  logic             result_valid_o;
  level_t           level_db_o;
  logic             zero_power_o;
  logic             last_bin_out_o;
  logic             cfg_we_i    = 1'b0;
  logic [0:0]       cfg_idx_i   = '0;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  db_level_board board = new();
  int            idle_pct;
  int            cycle_count = 0;

  // Directed bins: zero power, the smallest powers, zero-filled fractions and
  // the largest magnitudes of both signs.
  sample_t dir_re [12] = '{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd1, 16'sd3, 16'sd5,
                           -16'sd32768, 16'sd32767, -16'sd32768, 16'sd0, 16'sd181};
  sample_t dir_im [12] = '{16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd1, -16'sd2, 16'sd5,
                           -16'sd32768, 16'sd32767, 16'sd0, 16'sd32767, -16'sd181};
  logic    dir_last [12] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                             1'b1, 1'b0, 1'b0, 1'b0, 1'b0};

  fft_bin_magnitude_to_db DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .real_part_i    (real_part_i),
    .imag_part_i    (imag_part_i),
    .last_bin_i     (last_bin_i),
    .result_valid_o (result_valid_o),
    .level_db_o     (level_db_o),
    .zero_power_o   (zero_power_o),
    .last_bin_out_o (last_bin_out_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Every result strobe is a transfer; it is checked at the edge ending it.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      board.check_level(level_db_o, zero_power_o, last_bin_out_o);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // One bin transfer, with random idle cycles ahead of it.
  task automatic send_bin(sample_t re, sample_t im, logic last);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    real_part_i <= re;
    imag_part_i <= im;
    last_bin_i  <= last;
    do @(posedge clk_i); while (busy);
    board.note_bin(re, im, last);
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain_bins();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Writes both registers; junk goes into the unused bits of the full-scale word.
  task automatic write_settings(bit fs, gain_t gain);
    logic [CFG_W-1:0] fs_word;
    fs_word    = {11'($urandom), fs};
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegFullScale;
    cfg_data_i <= fs_word;
    @(posedge clk_i);
    board.note_reg(RegFullScale, fs_word);
    cfg_idx_i  <= RegGain;
    cfg_data_i <= gain;
    @(posedge clk_i);
    board.note_reg(RegGain, gain);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic run_directed();
    for (int i = 0; i < 12; i++) begin
      send_bin(dir_re[i], dir_im[i], dir_last[i]);
    end
    drain_bins();
  endtask

  // Components spread over all magnitudes so that every leading-one position
  // and every fraction index is reached.
  function automatic sample_t rand_component();
    int          w;
    logic [31:0] v;
    case ($urandom_range(7))
      0: return '0;
      1, 2: return sample_t'($urandom);
      3: begin
        case ($urandom_range(3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      default: begin
        w = $urandom_range(1, SW - 1);
        v = $urandom & ((32'd1 << w) - 1);
        if ($urandom_range(1)) v = -v;
        return sample_t'(v);
      end
    endcase
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      // Now and then the sender holds off until the pipeline has emptied.
      if ($urandom_range(59) == 0) drain_bins();
      send_bin(rand_component(), rand_component(), ($urandom_range(15) == 0));
    end
    drain_bins();
  endtask

  initial begin
    bit    fs_list [8]   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    gain_t gain_list [8] = '{-12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048,
                             12'sd0, 12'sd0, 12'sd0, 12'sd0};
    idle_pct = 25;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed bins under the reset settings, then under the other extreme.
    run_directed();
    write_settings(1'b1, 12'sd2047);
    run_directed();

    // Random phases, one setting each; the third runs without idle cycles.
    for (int p = 0; p < 8; p++) begin
      if (p >= 4) gain_list[p] = gain_t'($urandom);
      if (p >= 6) fs_list[p] = $urandom_range(1);
      write_settings(fs_list[p], gain_list[p]);
      idle_pct = (p == 2) ? 0 : 25;
      run_random(105);
    end

    repeat (16) @(posedge clk_i);
    if (board.pending() != 0) begin
      $error("%0d results never arrived", board.pending());
      board.fail_count++;
    end
    if (board.fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
